// ===== design/qlt_pkg.sv =====
// Shared constants, types and the log2 table for the query likelihood top-K scan.
// No dependencies.
`default_nettype none

package qlt_pkg;

    localparam int MAX_TERMS_DEF   = 16;
    localparam int TOPK_DEPTH_DEF  = 32;
    localparam int MAX_DOC_LEN_DEF = 255;

    localparam int MODE_W  = 2;
    localparam int SLOT_IN_W = 4;
    localparam int TID_W   = 24;
    localparam int CF_W    = 32;
    localparam int KEY_W   = 63;
    localparam int DLEN_W  = 8;
    localparam int RANK_W  = 7;
    localparam int SCORE_W = 32;
    localparam int HIT_W   = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 63;
    localparam int TCNT_W  = 5;
    localparam int MU_W    = 16;
    localparam int TOTAL_W = 40;

    localparam int LOG_X_W = 64;
    localparam int LOG_W   = 23;
    localparam int TAB_W   = 17;
    localparam int SUM_W   = 30;
    localparam int PROD_W  = 44;

    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam logic [15:0] MU_RESET = 16'd2500;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_TOKEN = 2'd1,
        MODE_FLUSH = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_LIMIT  = 2'd0,
        REG_TERM_COUNT  = 2'd1,
        REG_MU_VALUE    = 2'd2,
        REG_TOTAL_TERMS = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } topk_cmd_t;

    // round(65536*log2(1+i/32))
    localparam logic [TAB_W-1:0] LOG_TAB [0:32] = '{
        17'd0,     17'd2909,  17'd5732,  17'd8473,  17'd11136, 17'd13727,
        17'd16248, 17'd18704, 17'd21098, 17'd23433, 17'd25711, 17'd27936,
        17'd30109, 17'd32234, 17'd34312, 17'd36346, 17'd38336, 17'd40286,
        17'd42196, 17'd44068, 17'd45904, 17'd47705, 17'd49472, 17'd51207,
        17'd52911, 17'd54584, 17'd56229, 17'd57845, 17'd59434, 17'd60997,
        17'd62534, 17'd64047, 17'd65536
    };

endpackage

`default_nettype wire

// ===== design/qlt_if.sv =====
// Valid/ready channel interfaces for input and result words.
// Depends on qlt_pkg.
`default_nettype none

interface qlt_in_if;
    logic                          valid;
    logic                          ready;
    logic [qlt_pkg::MODE_W-1:0]    mode;
    logic [qlt_pkg::SLOT_IN_W-1:0] term_slot;
    logic [qlt_pkg::TID_W-1:0]     term_id;
    logic [qlt_pkg::CF_W-1:0]      collection_freq;
    logic [qlt_pkg::KEY_W-1:0]     doc_key;
    logic [qlt_pkg::DLEN_W-1:0]    doc_length;
    logic                          last_token;

    modport source (output valid, mode, term_slot, term_id, collection_freq, doc_key,
                    doc_length, last_token, input ready);
    modport sink (input valid, mode, term_slot, term_id, collection_freq, doc_key,
                  doc_length, last_token, output ready);
endinterface

interface qlt_out_if;
    logic                        valid;
    logic                        ready;
    logic [qlt_pkg::KEY_W-1:0]   out_key;
    logic [qlt_pkg::RANK_W-1:0]  rank;
    logic [qlt_pkg::SCORE_W-1:0] score;
    logic                        valid_res;
    logic                        last;

    modport source (output valid, out_key, rank, score, valid_res, last, input ready);
    modport sink (input valid, out_key, rank, score, valid_res, last, output ready);
endinterface

`default_nettype wire

// ===== design/qlt_log2.sv =====
// Iterative Q7.16 log2: six normalize steps, table interpolation, final add.
// Depends on qlt_pkg. done pulses once the final add has been registered after start.
`default_nettype none

module qlt_log2 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [qlt_pkg::LOG_X_W-1:0] x,
    output logic                        done,
    output logic [qlt_pkg::LOG_W-1:0]   result
);
    import qlt_pkg::*;

    logic [LOG_X_W-1:0] v_reg;
    logic [5:0]         z_reg;
    logic [2:0]         step_reg;
    logic               busy_reg;
    logic               zero_reg;
    logic [TAB_W-1:0]   base_reg;
    logic [11:0]        frac_reg;
    logic               done_reg;
    logic [LOG_W-1:0]   res_reg;

    logic               hi_zero;
    logic [LOG_X_W-1:0] v_sh;
    logic [5:0]         z_add;
    logic [4:0]         idx;
    logic [18:0]        rem;
    logic [TAB_W-1:0]   diff;
    logic [30:0]        prod;

    always_comb
    begin
        hi_zero = 1'b0;
        v_sh    = v_reg;
        z_add   = 6'd0;
        case (step_reg)
            3'd0:
            begin
                hi_zero = (v_reg[63:32] == '0);
                v_sh    = v_reg << 32;
                z_add   = 6'd32;
            end
            3'd1:
            begin
                hi_zero = (v_reg[63:48] == '0);
                v_sh    = v_reg << 16;
                z_add   = 6'd16;
            end
            3'd2:
            begin
                hi_zero = (v_reg[63:56] == '0);
                v_sh    = v_reg << 8;
                z_add   = 6'd8;
            end
            3'd3:
            begin
                hi_zero = (v_reg[63:60] == '0);
                v_sh    = v_reg << 4;
                z_add   = 6'd4;
            end
            3'd4:
            begin
                hi_zero = (v_reg[63:62] == '0);
                v_sh    = v_reg << 2;
                z_add   = 6'd2;
            end
            3'd5:
            begin
                hi_zero = ~v_reg[63];
                v_sh    = v_reg << 1;
                z_add   = 6'd1;
            end
            default:
            begin
                hi_zero = 1'b0;
            end
        endcase
    end

    assign idx  = v_reg[62:58];
    assign rem  = v_reg[57:39];
    assign diff = LOG_TAB[6'(idx) + 6'd1] - LOG_TAB[idx];
    assign prod = 31'(diff[11:0]) * 31'(rem);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= x;
            z_reg    <= '0;
            zero_reg <= (x == '0);
        end
        else if (busy_reg)
        begin
            if (step_reg < 3'd6)
            begin
                if (hi_zero)
                begin
                    v_reg <= v_sh;
                    z_reg <= z_reg + z_add;
                end
            end
            else if (step_reg == 3'd6)
            begin
                base_reg <= LOG_TAB[idx];
                frac_reg <= prod[30:19];
            end
            else
            begin
                res_reg <= zero_reg ? '0
                         : LOG_W'({~z_reg, 16'd0}) + LOG_W'(base_reg) + LOG_W'(frac_reg);
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== design/qlt_topk.sv =====
// Sorted top-K store as a row of cells: parallel insert and pop from the low end.
// Depends on qlt_pkg.
`default_nettype none

module qlt_topk #(
    parameter int DEPTH = qlt_pkg::TOPK_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  qlt_pkg::topk_cmd_t            cmd,
    input  logic [qlt_pkg::KEY_W-1:0]     new_key,
    input  logic [qlt_pkg::SCORE_W-1:0]   new_score,
    output logic [$clog2(DEPTH+1)-1:0]    count,
    output logic [qlt_pkg::KEY_W-1:0]     head_key,
    output logic [qlt_pkg::SCORE_W-1:0]   head_score
);
    import qlt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [KEY_W-1:0]   keys_reg   [DEPTH];
    logic [SCORE_W-1:0] scores_reg [DEPTH];
    logic [CW-1:0]      cnt_reg;

    logic [DEPTH-1:0]   le;
    logic               full;
    logic               accept;

    assign full   = (cnt_reg == CW'(DEPTH));
    assign accept = cmd.ins && (!full || (scores_reg[0] < new_score));

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            logic               up_le;
            logic [KEY_W-1:0]   up_key;
            logic [SCORE_W-1:0] up_score;
            logic               dn_le;
            logic [KEY_W-1:0]   dn_key;
            logic [SCORE_W-1:0] dn_score;

            assign le[k] = (CW'(k) < cnt_reg) && (scores_reg[k] <= new_score);

            if (k < DEPTH - 1)
            begin : g_up
                assign up_le    = le[k+1];
                assign up_key   = keys_reg[k+1];
                assign up_score = scores_reg[k+1];
            end
            else
            begin : g_top
                assign up_le    = 1'b0;
                assign up_key   = keys_reg[k];
                assign up_score = scores_reg[k];
            end

            if (k > 0)
            begin : g_dn
                assign dn_le    = le[k-1];
                assign dn_key   = keys_reg[k-1];
                assign dn_score = scores_reg[k-1];
            end
            else
            begin : g_bot
                assign dn_le    = 1'b1;
                assign dn_key   = new_key;
                assign dn_score = new_score;
            end

            always_ff @(posedge clk)
            begin
                if (cmd.pop)
                begin
                    keys_reg[k]   <= up_key;
                    scores_reg[k] <= up_score;
                end
                else if (accept && !full)
                begin
                    if (!le[k])
                    begin
                        if (dn_le)
                        begin
                            keys_reg[k]   <= new_key;
                            scores_reg[k] <= new_score;
                        end
                        else
                        begin
                            keys_reg[k]   <= dn_key;
                            scores_reg[k] <= dn_score;
                        end
                    end
                end
                else if (accept)
                begin
                    if (up_le)
                    begin
                        keys_reg[k]   <= up_key;
                        scores_reg[k] <= up_score;
                    end
                    else if (le[k])
                    begin
                        keys_reg[k]   <= new_key;
                        scores_reg[k] <= new_score;
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.pop)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
        else if (accept && !full)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    assign count      = cnt_reg;
    assign head_key   = keys_reg[0];
    assign head_score = scores_reg[0];

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("store count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (cnt_reg != '0) && !cmd.ins)
        else $error("pop from empty store or with insert");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !full && !cmd.pop) |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("insert into store with room did not grow count");

endmodule

`default_nettype wire

// ===== design/query_likelihood_topk_scan_core.sv =====
// Query likelihood top-K scan: load query terms, count token hits per term, score
// each finished document within the time limit with Dirichlet smoothing and keep the K best.
// Channels: tokens (qlt_in_if sink) and results (qlt_out_if source), valid/ready.
// Config: cfg_we/cfg_index/cfg_data write port, only while idle.
// Load words, tokens other than the last one of a document, unused words and the
// last token of a skipped document are accepted while tokens.ready stays high.
// A last token of a scored document keeps tokens.ready low while the shared log2 unit
// runs twice per document and twice per slot with hits, each slot in use is checked
// in turn, and the score is multiplied, rounded and inserted into the store; the
// multiply, round and insert do not happen when the sum is not positive.
// A flush word emits one result per held document, lowest score first, rank
// counting down from TOPK_DEPTH, last set on the final one; an empty store gives
// one word with valid_res low. Results leave through an output register, one per
// cycle, so a stalled receiver holds the flush in place; tokens.ready is low until
// the final result is in that register.
// Reset clears the hit counters, empties the store and sets the registers to
// time limit all ones, one term, mu 2500 and total 1. Query slots hold no reset
// value and must be loaded before use.
// Depends on qlt_pkg, qlt_if, qlt_log2, qlt_topk.
`default_nettype none

module query_likelihood_topk_scan_core #(
    parameter int MAX_TERMS   = qlt_pkg::MAX_TERMS_DEF,
    parameter int TOPK_DEPTH  = qlt_pkg::TOPK_DEPTH_DEF,
    parameter int MAX_DOC_LEN = qlt_pkg::MAX_DOC_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [qlt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qlt_pkg::CFG_DATA_W-1:0] cfg_data,
    qlt_in_if.sink                         tokens,
    qlt_out_if.source                      results
);
    import qlt_pkg::*;

    localparam int SLOT_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int LEN_W  = $clog2(MAX_DOC_LEN + 1);
    localparam int HC_W   = $clog2(TOPK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LMU, S_LLEN, S_SLOT, S_MUL, S_LAB, S_LB, S_FIN, S_RND, S_INS, S_FLUSH
    } state_t;

    // configuration
    logic [KEY_W-1:0]   time_limit_reg;
    logic [TCNT_W-1:0]  term_count_reg;
    logic [MU_W-1:0]    mu_value_reg;
    logic [TOTAL_W-1:0] total_terms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_limit_reg  <= '1;
            term_count_reg  <= TCNT_W'(1);
            mu_value_reg    <= MU_RESET;
            total_terms_reg <= TOTAL_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIME_LIMIT:  time_limit_reg  <= cfg_data;
                REG_TERM_COUNT:  term_count_reg  <= cfg_data[TCNT_W-1:0];
                REG_MU_VALUE:    mu_value_reg    <= cfg_data[MU_W-1:0];
                REG_TOTAL_TERMS: total_terms_reg <= cfg_data[TOTAL_W-1:0];
                default:         ;
            endcase
        end
    end

    state_t state_reg;

    logic [CNT_W-1:0]  n_eff;
    logic [MU_W-1:0]   mu_eff;
    logic              accept;
    logic              is_load, is_token, is_flush;

    assign n_eff  = (6'(term_count_reg) > 6'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                         : CNT_W'(term_count_reg);
    assign mu_eff = (mu_value_reg == '0) ? MU_W'(1) : mu_value_reg;

    assign tokens.ready = (state_reg == S_IDLE);
    assign accept   = tokens.valid && tokens.ready;
    assign is_load  = accept && (tokens.mode == MODE_LOAD);
    assign is_token = accept && (tokens.mode == MODE_TOKEN);
    assign is_flush = accept && (tokens.mode == MODE_FLUSH);

    // query slots and hit counters
    logic [TID_W-1:0] qterm_reg [MAX_TERMS];
    logic [CF_W-1:0]  qfreq_reg [MAX_TERMS];
    logic [HIT_W-1:0] hits_reg  [MAX_TERMS];
    logic             hits_clear;
    logic             skip_doc;
    logic [MAX_TERMS-1:0] hit_any;

    assign skip_doc = is_token && tokens.last_token && (tokens.doc_key > time_limit_reg);

    always_ff @(posedge clk)
    begin
        if (is_load && (5'(tokens.term_slot) < 5'(MAX_TERMS)))
        begin
            qterm_reg[tokens.term_slot[SLOT_W-1:0]] <= tokens.term_id;
            qfreq_reg[tokens.term_slot[SLOT_W-1:0]] <= tokens.collection_freq;
        end
    end

    genvar s;
    generate
        for (s = 0; s < MAX_TERMS; s++)
        begin : g_lane
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    hits_reg[s] <= '0;
                end
                else if (hits_clear || skip_doc)
                begin
                    hits_reg[s] <= '0;
                end
                else if (is_token && (CNT_W'(s) < n_eff) && (qterm_reg[s] == tokens.term_id)
                         && (hits_reg[s] != '1))
                begin
                    hits_reg[s] <= hits_reg[s] + HIT_W'(1);
                end
            end
            assign hit_any[s] = (hits_reg[s] != '0);
        end
    endgenerate

    // shared log2 unit
    logic               log_start_reg;
    logic [LOG_X_W-1:0] log_x_reg;
    logic               log_done;
    logic [LOG_W-1:0]   log_res;

    qlt_log2 u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start_reg),
        .x      (log_x_reg),
        .done   (log_done),
        .result (log_res)
    );

    // top-K store
    topk_cmd_t          st_cmd;
    logic [HC_W-1:0]    st_count;
    logic [KEY_W-1:0]   st_key;
    logic [SCORE_W-1:0] st_score;
    logic [KEY_W-1:0]   key_reg;
    logic [SCORE_W-1:0] sc_reg;
    logic               emit;

    qlt_topk #(.DEPTH(TOPK_DEPTH)) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (st_cmd),
        .new_key    (key_reg),
        .new_score  (sc_reg),
        .count      (st_count),
        .head_key   (st_key),
        .head_score (st_score)
    );

    logic                    out_valid_reg;
    assign emit = (state_reg == S_FLUSH) && (!out_valid_reg || results.ready);

    always_comb
    begin
        st_cmd.ins = (state_reg == S_INS) && (sc_reg != '0);
        st_cmd.pop = emit && (st_count != '0);
    end

    // sequencer datapath
    logic [LEN_W-1:0]        len_reg;
    logic [LOG_W-1:0]        lmu_reg;
    logic signed [LOG_W:0]   lterm_reg;
    logic [LOG_W-1:0]        lab_reg;
    logic [CNT_W-1:0]        slot_reg;
    logic [48:0]             a_reg;
    logic [48:0]             b_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [HC_W-1:0]         emit_idx_reg;
    logic [KEY_W-1:0]        out_key_reg;
    logic [RANK_W-1:0]       out_rank_reg;
    logic [SCORE_W-1:0]      out_score_reg;
    logic                    out_vres_reg;
    logic                    out_last_reg;

    logic [LEN_W-1:0]        len_clamp;
    logic [HIT_W-1:0]        cur_hits;
    logic [CF_W-1:0]         cur_freq;
    logic signed [SUM_W-1:0] term_val;
    logic [PROD_W:0]         rnd;

    assign hits_clear = (state_reg == S_INS) || ((state_reg == S_FIN) && (sum_reg <= 0));

    assign len_clamp = (16'(tokens.doc_length) > 16'(MAX_DOC_LEN)) ? LEN_W'(MAX_DOC_LEN)
                                                                   : LEN_W'(tokens.doc_length);
    assign cur_hits  = hits_reg[slot_reg[SLOT_W-1:0]];
    assign cur_freq  = qfreq_reg[slot_reg[SLOT_W-1:0]];
    assign term_val  = $signed(SUM_W'(lab_reg)) - $signed(SUM_W'(log_res))
                     + SUM_W'(lterm_reg);
    assign rnd       = (PROD_W+1)'(prod_reg) + (PROD_W+1)'(32768);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            log_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            log_start_reg <= 1'b0;
            if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (is_token && tokens.last_token && !skip_doc)
                    begin
                        key_reg       <= tokens.doc_key;
                        len_reg       <= len_clamp;
                        log_start_reg <= 1'b1;
                        log_x_reg     <= LOG_X_W'(mu_eff);
                        state_reg     <= S_LMU;
                    end
                    else if (is_flush)
                    begin
                        emit_idx_reg <= '0;
                        state_reg    <= S_FLUSH;
                    end
                end
                S_LMU:
                begin
                    if (log_done)
                    begin
                        lmu_reg       <= log_res;
                        log_start_reg <= 1'b1;
                        log_x_reg     <= LOG_X_W'(len_reg) + LOG_X_W'(mu_eff);
                        state_reg     <= S_LLEN;
                    end
                end
                S_LLEN:
                begin
                    if (log_done)
                    begin
                        lterm_reg <= $signed({1'b0, lmu_reg}) - $signed({1'b0, log_res});
                        slot_reg  <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_SLOT;
                    end
                end
                S_SLOT:
                begin
                    if (slot_reg >= n_eff)
                    begin
                        state_reg <= S_FIN;
                    end
                    else if (cur_hits == '0)
                    begin
                        slot_reg <= slot_reg + CNT_W'(1);
                    end
                    else
                    begin
                        a_reg     <= 49'(cur_hits) * (49'(total_terms_reg) + 49'd1);
                        b_reg     <= 49'(mu_eff) * (49'(cur_freq) + 49'd1);
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    log_start_reg <= 1'b1;
                    log_x_reg     <= LOG_X_W'(a_reg) + LOG_X_W'(b_reg);
                    state_reg     <= S_LAB;
                end
                S_LAB:
                begin
                    if (log_done)
                    begin
                        lab_reg       <= log_res;
                        log_start_reg <= 1'b1;
                        log_x_reg     <= LOG_X_W'(b_reg);
                        state_reg     <= S_LB;
                    end
                end
                S_LB:
                begin
                    if (log_done)
                    begin
                        sum_reg   <= sum_reg + term_val;
                        slot_reg  <= slot_reg + CNT_W'(1);
                        state_reg <= S_SLOT;
                    end
                end
                S_FIN:
                begin
                    if (sum_reg <= 0)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        prod_reg  <= PROD_W'(sum_reg[27:0]) * PROD_W'(LN2_Q16);
                        state_reg <= S_RND;
                    end
                end
                S_RND:
                begin
                    sc_reg    <= SCORE_W'(rnd[PROD_W:16]);
                    state_reg <= S_INS;
                end
                S_INS:
                begin
                    state_reg <= S_IDLE;
                end
                S_FLUSH:
                begin
                    if (emit)
                    begin
                        out_valid_reg <= 1'b1;
                        if (st_count == '0)
                        begin
                            out_key_reg   <= '0;
                            out_rank_reg  <= '0;
                            out_score_reg <= '0;
                            out_vres_reg  <= 1'b0;
                            out_last_reg  <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            out_key_reg   <= st_key;
                            out_rank_reg  <= RANK_W'(TOPK_DEPTH) - RANK_W'(emit_idx_reg);
                            out_score_reg <= st_score;
                            out_vres_reg  <= 1'b1;
                            out_last_reg  <= (st_count == HC_W'(1));
                            emit_idx_reg  <= emit_idx_reg + HC_W'(1);
                            if (st_count == HC_W'(1))
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.out_key   = out_key_reg;
    assign results.rank      = out_rank_reg;
    assign results.score     = out_score_reg;
    assign results.valid_res = out_vres_reg;
    assign results.last      = out_last_reg;

    a_empty_first: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (st_count == '0)) |-> (emit_idx_reg == '0))
        else $error("store ran empty in the middle of a flush");

    a_hits_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |=> (hit_any == '0))
        else $error("hit counters not cleared after scoring");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (st_count == HC_W'(1))) |=> (st_count == '0) && (state_reg == S_IDLE))
        else $error("flush ended with entries left");

endmodule

`default_nettype wire

// ===== dv/query_likelihood_topk_scan_core_tb.sv =====
// Testbench for query_likelihood_topk_scan_core: random and directed load, token,
// flush and unused words, scored against an in-bench top-K predictor in a scoreboard
// class. Depends on qlt_pkg, qlt_if and the core.
`default_nettype none

module query_likelihood_topk_scan_core_tb;
    import qlt_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic [1:0]        mode;
        logic [3:0]        slot;
        logic [TID_W-1:0]  tid;
        logic [CF_W-1:0]   cf;
        logic [KEY_W-1:0]  key;
        logic [DLEN_W-1:0] len;
        logic              lastt;
    } word_t;

    typedef struct {
        logic [KEY_W-1:0]   key;
        logic [RANK_W-1:0]  rank;
        logic [SCORE_W-1:0] score;
        logic               vld;
        logic               last;
    } rank_res_t;

    class topk_scoreboard;
        logic [KEY_W-1:0]   time_limit;
        logic [TCNT_W-1:0]  term_count;
        logic [MU_W-1:0]    mu;
        logic [TOTAL_W-1:0] total;
        logic [TID_W-1:0]   q_ids [MAX_TERMS_DEF];
        logic [CF_W-1:0]    q_cf [MAX_TERMS_DEF];
        int                 hits [MAX_TERMS_DEF];
        logic [KEY_W-1:0]   best_key [TOPK_DEPTH_DEF];
        logic [SCORE_W-1:0] best_score [TOPK_DEPTH_DEF];
        int                 held;
        rank_res_t          ranked_q [$];
        int                 errors;
        int                 words_in;
        int                 results_seen;
        int                 docs_stored;

        function new();
            time_limit = {KEY_W{1'b1}};
            term_count = 1;
            mu = MU_RESET;
            total = 1;
            held = 0;
            errors = 0;
            words_in = 0;
            results_seen = 0;
            docs_stored = 0;
            foreach (hits[i]) hits[i] = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_TIME_LIMIT:  time_limit = v;
                REG_TERM_COUNT:  term_count = v[TCNT_W-1:0];
                REG_MU_VALUE:    mu = v[MU_W-1:0];
                REG_TOTAL_TERMS: total = v[TOTAL_W-1:0];
                default: ;
            endcase
        endfunction

        function longint log2_q16(logic [63:0] x);
            int p;
            logic [63:0] f;
            int idx;
            longint rem;
            longint t;
            if (x == 0) return 0;
            p = 0;
            for (int b = 0; b < 64; b++) if (x[b]) p = b;
            if (p >= 24) f = (x >> (p - 24)) & 64'hFFFFFF;
            else f = (x << (24 - p)) & 64'hFFFFFF;
            idx = int'(f[23:19]);
            rem = longint'(f[18:0]);
            t = longint'(LOG_TAB[idx]) +
                (((longint'(LOG_TAB[idx+1]) - longint'(LOG_TAB[idx])) * rem) >>> 19);
            return (longint'(p) <<< 16) + t;
        endfunction

        function void insert_doc(logic [KEY_W-1:0] key, logic [SCORE_W-1:0] sc);
            int pos;
            if (held >= TOPK_DEPTH_DEF) begin
                if (sc <= best_score[0]) return;
                for (int k = 1; k < held; k++) begin
                    best_key[k-1] = best_key[k];
                    best_score[k-1] = best_score[k];
                end
                held--;
            end
            pos = 0;
            while (pos < held && best_score[pos] <= sc) pos++;
            for (int k = held; k > pos; k--) begin
                best_key[k] = best_key[k-1];
                best_score[k] = best_score[k-1];
            end
            best_key[pos] = key;
            best_score[pos] = sc;
            held++;
            docs_stored++;
        endfunction

        function void score_doc(logic [KEY_W-1:0] key, logic [DLEN_W-1:0] len);
            logic [63:0] m;
            logic [63:0] a;
            logic [63:0] b;
            int n;
            longint lterm;
            longint sum;
            logic [63:0] sc;
            m = (mu == 0) ? 64'd1 : 64'(mu);
            n = (term_count > MAX_TERMS_DEF) ? MAX_TERMS_DEF : int'(term_count);
            lterm = log2_q16(m) - log2_q16(64'(len) + m);
            sum = 0;
            for (int s = 0; s < n; s++) begin
                if (hits[s] != 0) begin
                    a = 64'(hits[s]) * (64'(total) + 64'd1);
                    b = m * (64'(q_cf[s]) + 64'd1);
                    sum += log2_q16(a + b) - log2_q16(b) + lterm;
                end
            end
            if (sum <= 0) return;
            sc = (64'(sum) * 64'(LN2_Q16) + 64'd32768) >> 16;
            if (sc > 64'hFFFFFFFF) sc = 64'hFFFFFFFF;
            if (sc == 0) return;
            insert_doc(key, sc[31:0]);
        endfunction

        function void note_word(word_t w);
            rank_res_t r;
            int n;
            words_in++;
            case (w.mode)
                MODE_LOAD:
                begin
                    q_ids[w.slot] = w.tid;
                    q_cf[w.slot] = w.cf;
                end
                MODE_TOKEN:
                begin
                    n = (term_count > MAX_TERMS_DEF) ? MAX_TERMS_DEF : int'(term_count);
                    for (int s = 0; s < n; s++)
                        if (q_ids[s] == w.tid && hits[s] < 255) hits[s]++;
                    if (w.lastt) begin
                        if (w.key <= time_limit) score_doc(w.key, w.len);
                        foreach (hits[i]) hits[i] = 0;
                    end
                end
                MODE_FLUSH:
                begin
                    if (held == 0) begin
                        r = '{key: '0, rank: '0, score: '0, vld: 1'b0, last: 1'b1};
                        ranked_q.push_back(r);
                    end
                    for (int k = 0; k < held; k++) begin
                        r.key = best_key[k];
                        r.rank = RANK_W'(TOPK_DEPTH_DEF - k);
                        r.score = best_score[k];
                        r.vld = 1'b1;
                        r.last = (k + 1 == held);
                        ranked_q.push_back(r);
                    end
                    held = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(rank_res_t got);
            rank_res_t e;
            results_seen++;
            if (ranked_q.size() == 0) begin
                $display("%0t unexpected result key %h score %h", $time, got.key, got.score);
                errors++;
                return;
            end
            e = ranked_q.pop_front();
            if (got.key !== e.key) begin
                $display("%0t out_key exp %h got %h", $time, e.key, got.key);
                errors++;
            end
            if (got.rank !== e.rank) begin
                $display("%0t rank exp %0d got %0d", $time, e.rank, got.rank);
                errors++;
            end
            if (got.score !== e.score) begin
                $display("%0t score exp %h got %h", $time, e.score, got.score);
                errors++;
            end
            if (got.vld !== e.vld) begin
                $display("%0t valid_res exp %b got %b", $time, e.vld, got.vld);
                errors++;
            end
            if (got.last !== e.last) begin
                $display("%0t last exp %b got %b", $time, e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    qlt_in_if tok_if ();
    qlt_out_if res_if ();

    topk_scoreboard sb = new();
    logic [TID_W-1:0] id_pool [MAX_TERMS_DEF];

    query_likelihood_topk_scan_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .tokens(tok_if),
        .results(res_if)
    );

    always #1 clk = ~clk;

    function int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // receiver stalls; long quiet stretches come from the longer gaps that pick_gap returns
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if ($urandom_range(3) == 0) stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result('{key: res_if.out_key, rank: res_if.rank, score: res_if.score,
                              vld: res_if.valid_res, last: res_if.last});
    end

    bit no_gaps = 0;

    task automatic send_word(word_t w);
        int gap;
        tok_if.valid <= 1'b1;
        tok_if.mode <= w.mode;
        tok_if.term_slot <= w.slot;
        tok_if.term_id <= w.tid;
        tok_if.collection_freq <= w.cf;
        tok_if.doc_key <= w.key;
        tok_if.doc_length <= w.len;
        tok_if.last_token <= w.lastt;
        do @(posedge clk); while (!(tok_if.valid && tok_if.ready));
        sb.note_word(w);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            tok_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        tok_if.valid <= 1'b0;
        while (sb.ranked_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic word_t mk(logic [1:0] mode, logic [3:0] slot, logic [TID_W-1:0] tid,
                                 logic [CF_W-1:0] cf, logic [KEY_W-1:0] key,
                                 logic [DLEN_W-1:0] len, logic lastt);
        word_t w;
        w = '{mode: mode, slot: slot, tid: tid, cf: cf, key: key, len: len, lastt: lastt};
        return w;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    task automatic load_all_slots();
        for (int s = 0; s < MAX_TERMS_DEF; s++) begin
            id_pool[s] = $urandom_range(3) == 0 ? TID_W'($urandom()) : TID_W'($urandom_range(40));
            send_word(mk(MODE_LOAD, s, id_pool[s], $urandom(), rand_key(),
                         $urandom(), $urandom_range(1)));
        end
    endtask

    task automatic send_doc(int ntok, logic [KEY_W-1:0] key, logic [DLEN_W-1:0] len,
                            int fixed_slot);
        logic [TID_W-1:0] tid;
        for (int t = 0; t < ntok; t++) begin
            if (fixed_slot >= 0) tid = id_pool[fixed_slot];
            else if ($urandom_range(9) < 7) tid = id_pool[$urandom_range(MAX_TERMS_DEF - 1)];
            else tid = $urandom();
            send_word(mk(MODE_TOKEN, $urandom(), tid, $urandom(), key, len, t == ntok - 1));
        end
    endtask

    task automatic random_phase(int nwords, int max_tok, bit with_long_doc);
        int sent;
        int r;
        int n;
        sent = 0;
        if (with_long_doc) begin
            send_doc(260, rand_key(), $urandom(), 0);
            sent += 260;
        end
        while (sent < nwords) begin
            r = $urandom_range(99);
            if (r < 3) begin
                send_word(mk(MODE_FLUSH, $urandom(), $urandom(), $urandom(), rand_key(),
                             $urandom(), $urandom_range(1)));
                sent++;
            end else if (r < 7) begin
                send_word(mk(MODE_UNUSED, $urandom(), $urandom(), $urandom(), rand_key(),
                             $urandom(), $urandom_range(1)));
            end else if (r < 10) begin
                n = $urandom_range(MAX_TERMS_DEF - 1);
                id_pool[n] = $urandom_range(40);
                send_word(mk(MODE_LOAD, n, id_pool[n], $urandom(), rand_key(),
                             $urandom(), $urandom_range(1)));
                sent++;
            end else begin
                n = $urandom_range(max_tok, 1);
                send_doc(n, $urandom_range(3) == 0 ? KEY_W'($urandom_range(50)) : rand_key(),
                         $urandom(), -1);
                sent += n;
            end
        end
        send_word(mk(MODE_FLUSH, 0, 0, 0, 0, 0, 0));
    endtask

    initial
    begin
        tok_if.valid = 1'b0;
        tok_if.mode = '0;
        tok_if.term_slot = '0;
        tok_if.term_id = '0;
        tok_if.collection_freq = '0;
        tok_if.doc_key = '0;
        tok_if.doc_length = '0;
        tok_if.last_token = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes of slots, ids, freqs, lengths and keys
        write_reg(REG_TERM_COUNT, MAX_TERMS_DEF);
        write_reg(REG_TOTAL_TERMS, 40'd1000000);
        for (int s = 0; s < MAX_TERMS_DEF; s++) begin
            id_pool[s] = (s == 0) ? '0 : (s == 15) ? {TID_W{1'b1}} : TID_W'(100 + s);
            send_word(mk(MODE_LOAD, s, id_pool[s], (s == 1) ? {CF_W{1'b1}} : CF_W'(s * 3),
                         '0, 8'd1, 1'b0));
        end
        send_word(mk(MODE_TOKEN, 0, id_pool[0], 0, 5, 10, 0));
        send_word(mk(MODE_TOKEN, 0, id_pool[1], 0, 5, 10, 0));
        send_word(mk(MODE_TOKEN, 0, id_pool[15], 0, 5, 10, 1));
        send_word(mk(MODE_TOKEN, 0, id_pool[2], 0, 0, 0, 1));
        send_word(mk(MODE_TOKEN, 0, id_pool[3], 0, {KEY_W{1'b1}}, 8'd255, 1));
        send_word(mk(MODE_TOKEN, 0, 24'hABCDEF, 0, 77, 3, 1));
        send_word(mk(MODE_UNUSED, 4'hF, {TID_W{1'b1}}, {CF_W{1'b1}}, {KEY_W{1'b1}}, 8'hFF, 1));
        send_word(mk(MODE_FLUSH, 0, 0, 0, 0, 0, 0));
        send_word(mk(MODE_FLUSH, 0, 0, 0, 0, 0, 0));
        drain();

        // mu and total at their extremes, single term
        write_reg(REG_MU_VALUE, 16'd1);
        write_reg(REG_TOTAL_TERMS, {TOTAL_W{1'b1}});
        write_reg(REG_TERM_COUNT, 1);
        load_all_slots();
        random_phase(25, 6, 0);
        drain();

        // many one-token docs to fill and overflow the store, no idling on the sender
        write_reg(REG_MU_VALUE, 16'hFFFF);
        write_reg(REG_TERM_COUNT, MAX_TERMS_DEF);
        write_reg(REG_TOTAL_TERMS, {TOTAL_W{1'b1}});
        no_gaps = 1;
        random_phase(80, 1, 0);
        no_gaps = 0;
        drain();

        // time limit in the middle
        write_reg(REG_TIME_LIMIT, 63'h4000_0000_0000_0000);
        write_reg(REG_MU_VALUE, 16'd2500);
        write_reg(REG_TOTAL_TERMS, 40'd123456789);
        write_reg(REG_TERM_COUNT, 5'($urandom_range(MAX_TERMS_DEF, 1)));
        load_all_slots();
        random_phase(25, 5, 0);
        drain();

        // only key zero passes
        write_reg(REG_TIME_LIMIT, '0);
        write_reg(REG_TOTAL_TERMS, 40'd1);
        random_phase(15, 4, 0);
        drain();

        write_reg(REG_TIME_LIMIT, {KEY_W{1'b1}});
        write_reg(REG_MU_VALUE, 16'($urandom_range(65535, 1)));
        write_reg(REG_TOTAL_TERMS, 40'($urandom()) + 40'd1);
        random_phase(20, 8, 0);
        drain();

        $display("run: %0d words accepted, %0d results checked, %0d docs stored",
                 sb.words_in, sb.results_seen, sb.docs_stored);
        $display("covered load/token/flush/unused words, empty and full store, six settings");
        if (sb.errors == 0 && sb.ranked_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end
endmodule

`default_nettype wire

// ===== query_likelihood_topk_scan_core.f =====
design/qlt_pkg.sv
design/qlt_if.sv
design/qlt_log2.sv
design/qlt_topk.sv
design/query_likelihood_topk_scan_core.sv
dv/query_likelihood_topk_scan_core_tb.sv
